>>> hdl/linear_probe_hash_table_top_defines.svh
// Assertion macros for the linear-probe hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define LPHT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lpht assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpht assertion failed");
`else
`define LPHT_ASSERT(lbl, prop)
`define LPHT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/lpht_pkg.sv
// Types and constants of the linear-probe hash table.
package lpht_pkg;

  // Table geometry; TABLE_SIZE is a power of two so home slot and wrap are bit slices
  localparam int unsigned TABLE_SIZE = 16;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned DATA_W     = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_e;

  typedef enum logic {
    FSM_IDLE  = 1'b0,
    FSM_PROBE = 1'b1
  } fsm_e;

endpackage

>>> hdl/linear_probe_hash_table_top.sv
// Linear-probe hash table: one insert, search or delete per transfer, one result each.
//
// The table holds TABLE_SIZE (16) slots; a key's home slot is its low bits and probing
// steps one slot per cycle, wrapping, for at most one full pass. An item is taken in and
// then visits its slots in turn; the single key compare unit steps the key/data memory
// one address a cycle. in_stall_o is high while an item is being worked on.
// The result sits in an output register, so the next item can be taken while a result
// still waits; a finished probe holds only while that register is still occupied and
// stalled. Insert does not check for duplicates and reports full after a pass with no
// free slot; search and delete stop at an empty slot, and delete leaves a tombstone.
// The slot-state store is cleared by reset, with no clearing pass.
`include "linear_probe_hash_table_top_defines.svh"

module linear_probe_hash_table_top
  import lpht_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               op_i,
  input  logic [KEY_W-1:0]         key_i,
  input  logic signed [DATA_W-1:0] value_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] value_out_o
);

  // Sequencer and item registers
  fsm_e                      state_q, state_d;
  logic [1:0]                op_q;
  logic [KEY_BITS-1:0]       key_q;
  logic [DATA_W-1:0]         val_q;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [IDX_W-1:0]          cnt_q, cnt_d;

  // Slot stores
  slot_e                     slot_state_q [TABLE_SIZE];
  logic [KEY_BITS-1:0]       key_mem [TABLE_SIZE];
  logic [DATA_W-1:0]         val_mem [TABLE_SIZE];
  logic [KEY_BITS-1:0]       rd_key_q;
  logic [DATA_W-1:0]         rd_val_q;

  // Output register
  logic                      out_valid_q, out_valid_d;
  status_e                   status_q;
  logic [DATA_W-1:0]         value_q;

  // Probe decision
  logic                      in_acc;
  logic                      out_free;
  logic                      fin;
  logic                      done;
  logic                      last;
  logic                      key_hit;
  slot_e                     slot_cur;
  status_e                   res_status;
  logic [DATA_W-1:0]         res_value;
  logic                      wr_ins;
  logic                      wr_del;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = (cnt_q == IDX_W'(TABLE_SIZE - 1));
  assign slot_cur = slot_state_q[idx_q];
  assign key_hit  = (slot_cur == SLOT_USED) && (rd_key_q == key_q);
  assign done     = fin && out_free;

  // One probe step: compare the current slot and decide
  always_comb begin
    fin        = 1'b0;
    res_status = STAT_NOT_FOUND;
    res_value  = '0;
    wr_ins     = 1'b0;
    wr_del     = 1'b0;
    if (state_q == FSM_PROBE) begin
      case (op_q)
        OP_INSERT: begin
          if (slot_cur != SLOT_USED) begin
            fin        = 1'b1;
            res_status = STAT_OK;
            wr_ins     = 1'b1;
          end else if (last) begin
            fin        = 1'b1;
            res_status = STAT_FULL;
          end
        end
        OP_SEARCH, OP_DELETE: begin
          if (slot_cur == SLOT_EMPTY) begin
            fin = 1'b1;
          end else if (key_hit) begin
            fin        = 1'b1;
            res_status = STAT_OK;
            res_value  = rd_val_q;
            wr_del     = (op_q == OP_DELETE);
          end else if (last) begin
            fin = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = FSM_PROBE;
        end
      end
      FSM_PROBE: begin
        if (done) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // State decode to handshake
  always_comb begin
    case (state_q)
      FSM_IDLE:  in_stall_o = 1'b0;
      FSM_PROBE: in_stall_o = 1'b1;
      default:   in_stall_o = 1'b1;
    endcase
  end

  // Probe address and pass counter
  always_comb begin
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      idx_d = key_i[IDX_W-1:0];
      cnt_d = '0;
    end else if (state_q == FSM_PROBE && !fin) begin
      idx_d = idx_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Output valid: set on finish, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
    end
  end

  // Item payload capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= op_i;
      key_q <= key_i[KEY_BITS-1:0];
      val_q <= value_in_i;
    end
  end

  // Result capture
  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q <= res_status;
      value_q  <= res_value;
    end
  end

  // Slot states, cleared to empty by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_state_q[i] <= SLOT_EMPTY;
      end
    end else if (done && wr_ins) begin
      slot_state_q[idx_q] <= SLOT_USED;
    end else if (done && wr_del) begin
      slot_state_q[idx_q] <= SLOT_DELETED;
    end
  end

  // Key/data memory: one write port, registered read at next probe address
  always_ff @(posedge clk_i) begin
    if (done && wr_ins) begin
      key_mem[idx_q] <= key_q;
      val_mem[idx_q] <= val_q;
    end
    rd_key_q <= key_mem[idx_d];
    rd_val_q <= val_mem[idx_d];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_q;

  // Checks
  `LPHT_ASSERT_NEXT(a_accept_probe, in_acc, state_q == FSM_PROBE && cnt_q == '0)
  `LPHT_ASSERT(a_step_in_probe, (state_q == FSM_PROBE && cnt_q != '0) |-> $past(state_q) == FSM_PROBE)
  `LPHT_ASSERT(a_full_only_insert, (fin && res_status == STAT_FULL) |-> (op_q == OP_INSERT && last))
  `LPHT_ASSERT(a_finish_slot_free, done |-> out_free && !(wr_ins && wr_del))

endmodule
